@@ sv/bpa_pkg.sv @@
package bpa_pkg;

  // Width used for page and range comparisons. It holds any page count,
  // any usable page count and a block size up to the largest order.
  localparam int CW = 18;

  // Width of the usable page count register.
  localparam int USABLE_W = 11;
  localparam logic [USABLE_W-1:0] USABLE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    op_t        operation;
    logic [3:0] order;
    logic [9:0] page_index;
  } req_t;

  typedef struct packed {
    logic [9:0] granted_page;
    status_t    status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_START,
    S_SEARCH,
    S_WAIT,
    S_UNLINK,
    S_UNL_CLR,
    S_A_CHK,
    S_SPLIT,
    S_PUSH1,
    S_PUSH2,
    S_F_STEP,
    S_RB_CLR,
    S_BUILD,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_req;
    logic    clr_heads;
    logic    sweep_step;
    logic    build_init;
    logic    build_step;
    logic    search_next;
    logic    pop;
    logic    unlink;
    logic    unlink_clr;
    logic    take_pg;
    logic    merge;
    logic    bud_sel;
    logic    split;
    logic    push_setup;
    logic    push1;
    logic    push2;
    logic    set_res;
    logic    res_grant;
    status_t res_status;
    logic    load_rsp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic ord_bad;
    logic page_bad;
    logic best_top;
    logic head_nil;
    logic at_order;
    logic split_oob;
    logic merge_stop;
    logic tag_hit;
    logic pg_bad;
    logic sweep_last;
    logic build_last;
    logic rsp_free;
  } sts_t;

endpackage

@@ sv/buddy_page_allocator_core.sv @@
// Allocate skips the empty free lists and then splits the block down one order per step,
// free merges with each free buddy in turn, and order errors, free range errors and no-op
// go straight to the result; rebuild clears every page and then builds the lists by order.
// One item is in work at a time; the next is taken in the cycle after the result is loaded,
// which waits while the previous result is still held. The rate is set by the page tables.
// Reset is synchronous; afterwards the tag table is cleared one page a cycle, from the first
// page to the last, during which req_ready stays low.
module buddy_page_allocator_core #(
  parameter int PAGE_COUNT  = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpa_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [bpa_pkg::USABLE_W-1:0] usable;
  bpa_pkg::cmd_t                cmd;
  bpa_pkg::sts_t                sts;

  // Configuration register: usable page count.
  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= bpa_pkg::USABLE_RESET;
    end else if (psel && penable && pwrite) begin
      usable <= pwdata[bpa_pkg::USABLE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(usable) : 32'd0;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dpath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .usable    (usable),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // A failed item never carries a page.
  a_fail_no_page: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bpa_pkg::ST_OK) |-> (rsp.granted_page == 10'd0))
    else $error("failed item carries a page");

  // No table is touched while the block waits for an item.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !(cmd.unlink || cmd.push1 || cmd.push2 || cmd.sweep_step ||
                    cmd.build_step))
    else $error("table write while idle");

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |-> sts.rsp_free)
    else $error("result overwritten");

  // An accepted item cannot produce its result in the next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !cmd.load_rsp)
    else $error("result loaded too early");
`endif

endmodule

@@ sv/bpa_ctrl.sv @@
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;

  // State register; reset starts the tag memory clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      bpa_pkg::S_INIT_CLR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = bpa_pkg::S_START;
        end
      end
      bpa_pkg::S_START: begin
        case (sts.op)
          bpa_pkg::OP_ALLOC: begin
            if (sts.ord_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = bpa_pkg::ST_BAD_ORDER;
              state_next     = bpa_pkg::S_DONE;
            end else begin
              state_next = bpa_pkg::S_SEARCH;
            end
          end
          bpa_pkg::OP_FREE: begin
            if (sts.ord_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = bpa_pkg::ST_BAD_ORDER;
              state_next     = bpa_pkg::S_DONE;
            end else if (sts.page_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = bpa_pkg::ST_RANGE;
              state_next     = bpa_pkg::S_DONE;
            end else begin
              state_next = bpa_pkg::S_F_STEP;
            end
          end
          bpa_pkg::OP_REBUILD: begin
            cmd.clr_heads = 1'b1;
            state_next    = bpa_pkg::S_RB_CLR;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = bpa_pkg::ST_OK;
            state_next     = bpa_pkg::S_DONE;
          end
        endcase
      end
      // Walk up the free lists until one is not empty or none is left.
      bpa_pkg::S_SEARCH: begin
        if (sts.best_top) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = bpa_pkg::ST_NO_BLOCK;
          state_next     = bpa_pkg::S_DONE;
        end else if (sts.head_nil) begin
          cmd.search_next = 1'b1;
        end else begin
          cmd.pop    = 1'b1;
          state_next = bpa_pkg::S_WAIT;
        end
      end
      bpa_pkg::S_WAIT: begin
        state_next = bpa_pkg::S_UNLINK;
      end
      bpa_pkg::S_UNLINK: begin
        if (sts.op == bpa_pkg::OP_FREE && !sts.tag_hit) begin
          cmd.push_setup = 1'b1;
          state_next     = bpa_pkg::S_PUSH1;
        end else if (sts.op == bpa_pkg::OP_FREE) begin
          cmd.unlink = 1'b1;
          cmd.merge  = 1'b1;
          state_next = bpa_pkg::S_UNL_CLR;
        end else begin
          cmd.unlink  = 1'b1;
          cmd.take_pg = 1'b1;
          state_next  = bpa_pkg::S_UNL_CLR;
        end
      end
      // The unlinked page gets null links once its neighbors are patched.
      bpa_pkg::S_UNL_CLR: begin
        cmd.unlink_clr = 1'b1;
        if (sts.op == bpa_pkg::OP_FREE) begin
          state_next = bpa_pkg::S_F_STEP;
        end else begin
          state_next = bpa_pkg::S_A_CHK;
        end
      end
      bpa_pkg::S_A_CHK: begin
        if (sts.pg_bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = bpa_pkg::ST_RANGE;
          state_next     = bpa_pkg::S_DONE;
        end else begin
          state_next = bpa_pkg::S_SPLIT;
        end
      end
      // Hand the upper half down one order at a time.
      bpa_pkg::S_SPLIT: begin
        if (sts.at_order) begin
          cmd.set_res    = 1'b1;
          cmd.res_grant  = 1'b1;
          cmd.res_status = bpa_pkg::ST_OK;
          state_next     = bpa_pkg::S_DONE;
        end else begin
          cmd.split = 1'b1;
          if (!sts.split_oob) begin
            state_next = bpa_pkg::S_PUSH1;
          end
        end
      end
      bpa_pkg::S_PUSH1: begin
        cmd.push1  = 1'b1;
        state_next = bpa_pkg::S_PUSH2;
      end
      bpa_pkg::S_PUSH2: begin
        cmd.push2 = 1'b1;
        if (sts.op == bpa_pkg::OP_ALLOC) begin
          state_next = bpa_pkg::S_SPLIT;
        end else begin
          cmd.set_res    = 1'b1;
          cmd.res_status = bpa_pkg::ST_OK;
          state_next     = bpa_pkg::S_DONE;
        end
      end
      // One merge attempt per pass: check the buddy, then unlink it; when merging stops, push the block.
      bpa_pkg::S_F_STEP: begin
        if (sts.merge_stop) begin
          cmd.push_setup = 1'b1;
          state_next     = bpa_pkg::S_PUSH1;
        end else begin
          cmd.bud_sel = 1'b1;
          state_next  = bpa_pkg::S_WAIT;
        end
      end
      bpa_pkg::S_RB_CLR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.build_init = 1'b1;
          state_next     = bpa_pkg::S_BUILD;
        end
      end
      bpa_pkg::S_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.build_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = bpa_pkg::ST_OK;
          state_next     = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_DONE: begin
        if (sts.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/bpa_dpath.sv @@
module bpa_dpath #(
  parameter int PAGE_COUNT  = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bpa_pkg::req_t                  req,
  input  logic [bpa_pkg::USABLE_W-1:0]   usable,
  input  bpa_pkg::cmd_t                  cmd,
  output bpa_pkg::sts_t                  sts,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bpa_pkg::rsp_t                  rsp
);

  localparam int AW  = (PAGE_COUNT > 2) ? $clog2(PAGE_COUNT) : 1;
  localparam int OW  = ($clog2(ORDER_COUNT + 1) > 4) ? $clog2(ORDER_COUNT + 1) : 4;
  localparam int HW  = $clog2(ORDER_COUNT);
  localparam int NW  = AW + 1;
  localparam int PLW = (AW > OW) ? AW : OW;
  localparam int PVW = PLW + 1;
  localparam int CW  = bpa_pkg::CW;

  localparam logic [NW-1:0]  NEXT_NIL  = {1'b1, {AW{1'b0}}};
  localparam logic [PVW-1:0] PREV_NIL  = {PVW{1'b1}};
  localparam logic [OW-1:0]  TAG_NONE  = OW'(15);
  localparam logic [CW-1:0]  PAGE_LIM  = CW'(PAGE_COUNT);
  localparam logic [AW-1:0]  LAST_PAGE = AW'(PAGE_COUNT - 1);
  localparam logic [OW-1:0]  TOP_ORDER = OW'(ORDER_COUNT - 1);

  // Working registers.
  bpa_pkg::req_t       req_r;
  logic [AW-1:0]       pg;
  logic [AW-1:0]       cur;
  logic [OW-1:0]       ord;
  logic [OW-1:0]       best;
  logic [OW-1:0]       oc;
  logic [NW-1:0]       link;
  logic [NW-1:0]       heads [ORDER_COUNT];
  bpa_pkg::status_t    res_status;
  logic [9:0]          res_page;

  // Per-page tables.
  logic [OW-1:0]       tag_mem  [PAGE_COUNT];
  logic [NW-1:0]       next_mem [PAGE_COUNT];
  logic [PVW-1:0]      prev_mem [PAGE_COUNT];
  logic [OW-1:0]       tag_q;
  logic [NW-1:0]       next_q;
  logic [PVW-1:0]      prev_q;

  logic                tag_we;
  logic [AW-1:0]       tag_wa;
  logic [OW-1:0]       tag_wd;
  logic                next_we;
  logic [AW-1:0]       next_wa;
  logic [NW-1:0]       next_wd;
  logic                prev_we;
  logic [AW-1:0]       prev_wa;
  logic [PVW-1:0]      prev_wd;

  logic [CW-1:0]       use_pages;
  logic [CW-1:0]       use_sh;
  logic [CW-1:0]       pg_x;
  logic [CW-1:0]       ord_bit;
  logic [CW-1:0]       best_bit;
  logic [OW-1:0]       best_dn;
  logic [CW-1:0]       dn_bit;
  logic [CW-1:0]       bud_x;
  logic [CW-1:0]       split_x;
  logic [CW-1:0]       build_x;
  logic [NW-1:0]       head_sel;
  logic [PVW-1:0]      prev_head;
  logic [PVW-1:0]      prev_page;

  // Address arithmetic and range checks.
  always_comb begin
    use_pages = (CW'(usable) > PAGE_LIM) ? PAGE_LIM : CW'(usable);
    use_sh    = use_pages >> best;
    pg_x      = CW'(pg);
    ord_bit   = CW'(1) << ord;
    best_bit  = CW'(1) << best;
    best_dn   = best - OW'(1);
    dn_bit    = CW'(1) << best_dn;
    bud_x     = pg_x ^ ord_bit;
    split_x   = pg_x + dn_bit;
    build_x   = pg_x + best_bit;
    head_sel  = heads[best[HW-1:0]];
    prev_head = {1'b1, PLW'(best)};
    prev_page = {1'b0, PLW'(cur)};
  end

  // Status toward the controller.
  always_comb begin
    sts.op         = req_r.operation;
    sts.ord_bad    = CW'(req_r.order) >= CW'(oc);
    sts.page_bad   = CW'(req_r.page_index) >= use_pages;
    sts.best_top   = best >= oc;
    sts.head_nil   = head_sel[NW-1];
    sts.at_order   = best == ord;
    sts.split_oob  = split_x >= PAGE_LIM;
    sts.merge_stop = (CW'(ord) + CW'(1) >= CW'(oc)) || (bud_x >= use_pages);
    sts.tag_hit    = tag_q == ord;
    sts.pg_bad     = pg_x >= use_pages;
    sts.sweep_last = cur == LAST_PAGE;
    sts.build_last = best == '0;
    sts.rsp_free   = !rsp_valid || rsp_ready;
  end

  // Write port selection for the three page tables.
  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = cur;
    tag_wd  = TAG_NONE;
    next_we = 1'b0;
    next_wa = cur;
    next_wd = NEXT_NIL;
    prev_we = 1'b0;
    prev_wa = cur;
    prev_wd = prev_page;
    if (cmd.sweep_step) begin
      tag_we = 1'b1;
    end
    if (cmd.build_step && use_sh[0]) begin
      tag_we  = 1'b1;
      tag_wa  = pg;
      tag_wd  = best;
      next_we = 1'b1;
      next_wa = pg;
      prev_we = 1'b1;
      prev_wa = pg;
      prev_wd = prev_head;
    end
    if (cmd.unlink) begin
      tag_we = 1'b1;
      if (!prev_q[PVW-1]) begin
        next_we = 1'b1;
        next_wa = prev_q[AW-1:0];
        next_wd = next_q;
      end
      if (!next_q[NW-1]) begin
        prev_we = 1'b1;
        prev_wa = next_q[AW-1:0];
        prev_wd = prev_q;
      end
    end
    if (cmd.unlink_clr) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      prev_wd = PREV_NIL;
    end
    if (cmd.push1) begin
      tag_we  = 1'b1;
      tag_wd  = best;
      next_we = 1'b1;
      next_wd = head_sel;
      prev_we = 1'b1;
      prev_wd = prev_head;
    end
    // A page pushed onto a list that it already heads keeps its head mark.
    if (cmd.push2 && !link[NW-1] && link[AW-1:0] != cur) begin
      prev_we = 1'b1;
      prev_wa = link[AW-1:0];
      prev_wd = prev_page;
    end
  end

  // Page tables, read every cycle at the current page.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    tag_q  <= tag_mem[cur];
    next_q <= next_mem[cur];
    prev_q <= prev_mem[cur];
  end

  // List heads, order count, current page and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      oc        <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        heads[i] <= NEXT_NIL;
      end
    end else begin
      if (cmd.clr_heads) begin
        cur <= '0;
        oc  <= '0;
        for (int i = 0; i < ORDER_COUNT; i++) begin
          heads[i] <= NEXT_NIL;
        end
      end
      if (cmd.sweep_step) begin
        cur <= cur + AW'(1);
      end
      if (cmd.build_step) begin
        if (use_sh[0]) begin
          heads[best[HW-1:0]] <= {1'b0, pg};
        end
        if (oc == '0 && use_sh != '0) begin
          oc <= best + OW'(1);
        end
      end
      if (cmd.pop) begin
        cur <= head_sel[AW-1:0];
      end
      if (cmd.unlink && prev_q[PVW-1] && prev_q != PREV_NIL) begin
        heads[prev_q[HW-1:0]] <= next_q;
      end
      if (cmd.bud_sel) begin
        cur <= AW'(bud_x);
      end
      if (cmd.split) begin
        cur <= AW'(split_x);
      end
      if (cmd.push_setup) begin
        cur <= pg;
      end
      if (cmd.push1) begin
        heads[best[HW-1:0]] <= {1'b0, cur};
      end
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= req;
      pg    <= AW'(req.page_index);
      ord   <= OW'(req.order);
      best  <= OW'(req.order);
    end
    if (cmd.build_init) begin
      best <= TOP_ORDER;
      pg   <= '0;
    end
    if (cmd.build_step) begin
      best <= best_dn;
      if (use_sh[0]) begin
        pg <= AW'(build_x);
      end
    end
    if (cmd.search_next) begin
      best <= best + OW'(1);
    end
    if (cmd.take_pg) begin
      pg <= cur;
    end
    if (cmd.merge) begin
      ord <= ord + OW'(1);
      pg  <= AW'(pg_x & ~ord_bit);
    end
    if (cmd.split) begin
      best <= best_dn;
    end
    if (cmd.push_setup) begin
      best <= ord;
    end
    if (cmd.push1) begin
      link <= head_sel;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_page   <= cmd.res_grant ? pg_x[9:0] : 10'd0;
    end
    if (cmd.load_rsp) begin
      rsp.granted_page <= res_page;
      rsp.status       <= res_status;
    end
  end

endmodule
